### design/wps_pkg.sv
// shared types, constants and the byte-wide lfsr step for the packet scrambler
// no dependencies
`default_nettype none
package wps_pkg;

    localparam logic [10:0] POS_MAX      = 11'd2047;
    localparam logic [10:0] PKT_SIZE_RST = 11'd1515;
    localparam logic [10:0] PASS_BYTES   = 11'd3;
    localparam logic [10:0] SEED_BYTE    = 11'd3;
    localparam logic [7:0]  SEED_STEP    = 8'd37;
    localparam logic [7:0]  SEED_MOD     = 8'd127;
    localparam logic [6:0]  SEED_RST     = 7'd1;

    typedef struct packed {
        logic [7:0]  pipe_byte;
        logic        packet_start;
        logic [15:0] meaningful_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] seq;
        logic [6:0] next;
    } t_lfsr_out;

    // eight steps of x^7 + x^4 + 1, output bit taken lsb first
    function automatic t_lfsr_out lfsr_byte(input logic [6:0] state);
        t_lfsr_out  res;
        logic [6:0] r;
        logic       fb;
        r = state;
        res.seq = 8'd0;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ r[3];
            res.seq[k] = r[0];
            r = {fb, r[6:1]};
        end
        res.next = r;
        return res;
    endfunction

endpackage
`default_nettype wire

### design/wps_in_stage.sv
// input register of the scrambler with stall generation towards the source
// depends on wps_pkg
`default_nettype none
module wps_in_stage
    import wps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_pipe_byte,
    input  wire        i_packet_start,
    input  wire [15:0] i_meaningful_length,
    input  wire        i_advance,
    output logic       o_item_valid,
    output t_in_item   o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.pipe_byte         <= i_pipe_byte;
            r_item.packet_start      <= i_packet_start;
            r_item.meaningful_length <= i_meaningful_length;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule
`default_nettype wire

### design/wps_scramble.sv
// per-packet state (lfsr, position, length, seed) and the result byte logic
// depends on wps_pkg
`default_nettype none
module wps_scramble
    import wps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_fire,
    input  t_in_item   i_item,
    input  wire [10:0] i_packet_size,
    output logic [7:0] o_out_byte
);

    logic [6:0]  r_lfsr;
    logic [10:0] r_pos;
    logic [10:0] r_held;
    logic [6:0]  r_residue;
    logic [6:0]  r_seed;

    logic [6:0]  n_lfsr;
    logic [10:0] n_pos;
    logic [10:0] n_held;
    logic [6:0]  n_residue;
    logic [6:0]  n_seed;

    logic [7:0]  w_res_sum;
    t_lfsr_out   w_seq;
    logic [7:0]  w_mix;

    always_comb begin
        w_res_sum = {1'b0, r_residue} + SEED_STEP;
        if (i_item.packet_start) begin
            n_seed    = r_residue + 7'd1;
            n_residue = (w_res_sum >= SEED_MOD) ? 7'(w_res_sum - SEED_MOD) : w_res_sum[6:0];
            n_held    = (i_item.meaningful_length > {5'd0, i_packet_size})
                        ? i_packet_size : i_item.meaningful_length[10:0];
            n_pos     = 11'd0;
            w_seq     = lfsr_byte(n_seed);
        end else begin
            n_seed    = r_seed;
            n_residue = r_residue;
            n_held    = r_held;
            n_pos     = (r_pos < POS_MAX) ? r_pos + 11'd1 : r_pos;
            w_seq     = lfsr_byte(r_lfsr);
        end
        n_lfsr = w_seq.next;

        w_mix = i_item.pipe_byte ^ w_seq.seq;
        if (n_pos >= n_held) begin
            o_out_byte = 8'd0;
        end else if (n_pos < PASS_BYTES) begin
            o_out_byte = i_item.pipe_byte;
        end else if (n_pos == SEED_BYTE) begin
            o_out_byte = {w_mix[7], n_seed};
        end else begin
            o_out_byte = w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr    <= 7'd0;
            r_pos     <= 11'd0;
            r_held    <= 11'd0;
            r_residue <= 7'd0;
            r_seed    <= SEED_RST;
        end else if (i_fire) begin
            r_lfsr    <= n_lfsr;
            r_pos     <= n_pos;
            r_held    <= n_held;
            r_residue <= n_residue;
            r_seed    <= n_seed;
        end
    end

endmodule
`default_nettype wire

### design/wlan_packet_scrambler.sv
// top level of the packet scrambler: config register, input stage, scrambler, result register
// depends on wps_pkg, wps_in_stage and wps_scramble
`default_nettype none
// Scrambles one pipe byte per clock cycle while the sink does not stall. An item passes
// an input register and then a result register, from which its result is presented;
// the 7-bit LFSR advances eight steps in the single stage between them, which sets
// the rate of one item per cycle. The stall towards the source rises only while both
// registers hold items and the sink stalls. The packet_size register is always ready;
// the user must write it only while the block is idle, which the block does not enforce.
module wlan_packet_scrambler
    import wps_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [7:0]  i_pipe_byte,
    input  wire        i_packet_start,
    input  wire [15:0] i_meaningful_length,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_byte,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [10:0] i_cfg_packet_size
);

    logic [10:0] r_packet_size;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        w_advance;
    logic        w_item_valid;
    t_in_item    w_item;
    logic [7:0]  w_result;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_size <= PKT_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_packet_size <= i_cfg_packet_size;
        end
    end

    wps_in_stage u_in_stage (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_pipe_byte         (i_pipe_byte),
        .i_packet_start      (i_packet_start),
        .i_meaningful_length (i_meaningful_length),
        .i_advance           (w_advance),
        .o_item_valid        (w_item_valid),
        .o_item              (w_item)
    );

    wps_scramble u_scramble (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_item_valid && w_advance),
        .i_item        (w_item),
        .i_packet_size (r_packet_size),
        .o_out_byte    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_item_valid) begin
            r_out_byte <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

endmodule
`default_nettype wire

### design/wps_checker.sv
// port-level checks for the packet scrambler and their binding to the top level
// depends on wlan_packet_scrambler
`default_nettype none
module wps_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [7:0] o_out_byte
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("stalled item changed");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> ##1 o_out_valid)
        else $error("accepted item not delivered");

endmodule

bind wlan_packet_scrambler wps_checker u_wps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte)
);
`default_nettype wire

### verif/wlan_packet_scrambler_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for wlan_packet_scrambler: directed and random byte streams,
// with a byte-level scrambler predictor checked against every output item
// depends on wps_pkg and the wlan_packet_scrambler rtl
module wlan_packet_scrambler_tb;
    import wps_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 100;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  pipe_byte = 8'd0;
    logic        packet_start = 1'b0;
    logic [15:0] meaningful_length = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_packet_size = 11'd0;

    // predictor state
    logic [6:0]  pred_lfsr = 7'd0;
    logic [10:0] pred_pos = 11'd0;
    logic [10:0] pred_len = 11'd0;
    logic [6:0]  pred_residue = 7'd0;
    logic [6:0]  pred_seed = SEED_RST;
    logic [10:0] pred_pkt_size = PKT_SIZE_RST;

    logic [7:0]  expected_bytes[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;

    wlan_packet_scrambler dut (
        .i_clk               (i_clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_pipe_byte         (pipe_byte),
        .i_packet_start      (packet_start),
        .i_meaningful_length (meaningful_length),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_out_byte          (out_byte),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_packet_size   (cfg_packet_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic logic [7:0] scramble_predict(input logic [7:0] b, input logic st,
                                                    input logic [15:0] len);
        logic [7:0] seq;
        logic [7:0] res;
        logic [6:0] r;
        logic       fb;
        int         step;
        if (st) begin
            pred_len = (len > {5'd0, pred_pkt_size}) ? pred_pkt_size : len[10:0];
            pred_seed = pred_residue + 7'd1;
            step = (int'(pred_residue) + int'(SEED_STEP)) % int'(SEED_MOD);
            pred_residue = 7'(step);
            pred_lfsr = pred_seed;
            pred_pos = 11'd0;
        end else if (pred_pos != POS_MAX) begin
            pred_pos = pred_pos + 11'd1;
        end
        r = pred_lfsr;
        seq = 8'd0;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ r[3];
            seq[k] = r[0];
            r = {fb, r[6:1]};
        end
        pred_lfsr = r;
        if (pred_pos >= pred_len) begin
            res = 8'd0;
        end else if (pred_pos < PASS_BYTES) begin
            res = b;
        end else begin
            res = b ^ seq;
            if (pred_pos == SEED_BYTE) begin
                res = {res[7], pred_seed};
            end
        end
        return res;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic st, input logic [15:0] len);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid          <= 1'b1;
        pipe_byte         <= b;
        packet_start      <= st;
        meaningful_length <= len;
        do @(posedge i_clk); while (in_stall);
        expected_bytes.push_back(scramble_predict(b, st, len));
    endtask

    task automatic send_packet(input logic [15:0] len, input int n_bytes);
        send_byte(8'($urandom), 1'b1, len);
        for (int k = 1; k < n_bytes; k++) begin
            send_byte(8'($urandom), 1'b0, 16'($urandom));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_packet_size(input logic [10:0] v);
        wait_drained();
        cfg_valid       <= 1'b1;
        cfg_packet_size <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pred_pkt_size = v;
    endtask

    // output check and sink stall
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected item %02h", out_byte));
            end else begin
                if (out_byte !== expected_bytes[0]) begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, expected_bytes[0]));
                end
                void'(expected_bytes.pop_front());
            end
        end
        out_stall <= idle_on && ($urandom_range(0, 99) < 20);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_before_start();
        send_byte(8'h00, 1'b0, 16'hFFFF);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
        send_byte(8'hA5, 1'b0, 16'h0000);
    endtask

    task automatic test_field_extremes();
        send_byte(8'hFF, 1'b1, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'h80, 1'b0, 16'hFFFF);
        send_byte(8'h7F, 1'b0, 16'h5555);
        send_byte(8'hFF, 1'b0, 16'hAAAA);
        send_byte(8'h00, 1'b0, 16'h0000);
        send_byte(8'hFF, 1'b1, 16'h0000);
        send_byte(8'hFF, 1'b0, 16'hFFFF);
    endtask

    // lengths below the seed byte, then the shortest full header
    task automatic test_short_lengths();
        for (int n = 1; n <= 4; n++) begin
            send_packet(16'(n), 4);
        end
        send_byte(8'hFF, 1'b0, 16'h0000);
    endtask

    task automatic test_size_limits();
        write_packet_size(11'd4);
        send_packet(16'hFFFF, 6);
        write_packet_size(11'd3);
        send_packet(16'd100, 5);
        write_packet_size(11'd0);
        send_packet(16'd7, 2);
    endtask

    // one packet running past the largest slot, so the position saturates
    task automatic test_long_packet();
        write_packet_size(11'd2047);
        idle_on = 1'b0;
        send_packet(16'hFFFF, 2052);
        idle_on = 1'b1;
    endtask

    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        int n_bytes;
        logic [15:0] len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_byte(8'($urandom), 1'($urandom), 16'($urandom));
                sent++;
            end else begin
                if (pick < 70) begin
                    len = 16'($urandom_range(0, 20));
                end else if (pick < 90) begin
                    len = 16'($urandom_range(0, 2047));
                end else begin
                    len = 16'($urandom);
                end
                n_bytes = $urandom_range(1, 20);
                send_packet(len, n_bytes);
                sent += n_bytes;
            end
        end
    endtask

    task automatic test_random_packets();
        write_packet_size(PKT_SIZE_RST);
        random_traffic(100);
        write_packet_size(11'($urandom_range(4, 40)));
        idle_on = 1'b0;
        random_traffic(100);
        idle_on = 1'b1;
        write_packet_size(11'd4);
        random_traffic(100);
        write_packet_size(11'd2047);
        random_traffic(100);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_start();
        test_field_extremes();
        test_short_lengths();
        test_size_limits();
        test_long_packet();
        test_random_packets();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
